>>> rtl/sipt_pkg.sv
// shared types, constants and helpers of the sip/puff brake-throttle integrator
`timescale 1ns / 1ps

package sipt_pkg;

  // fixed-point format of percent values
  localparam int FRAC_BITS = 8;

  // field widths
  localparam int PRESS_W    = 16;
  localparam int DT_W       = 20;
  localparam int CMD_W      = 16;
  localparam int MODE_W     = 2;
  localparam int GAIN_W     = 16;
  localparam int DB_W       = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // elapsed time clamp, microseconds
  localparam int DTC_W  = 17;
  localparam int DT_MIN = 1000;
  localparam int DT_MAX = 100000;

  // percent limits in Q(FRAC_BITS), and the suck gain floor
  localparam int LIMIT      = 100 << FRAC_BITS;
  localparam int STRONG     = 75 << FRAC_BITS;
  localparam int LIGHT      = 10 << FRAC_BITS;
  localparam int SUCK_FLOOR = 26;

  // integral width, never narrower than the command field
  localparam int INT_BITS = $clog2(LIMIT + 1) + 1;
  localparam int INT_W    = (INT_BITS > CMD_W) ? INT_BITS : CMD_W;
  localparam int CMP_W    = INT_W + 2;

  // rate = gain * pressure + throttle base, signed
  localparam int RATE_W = ((GAIN_W + FRAC_BITS > 32) ? GAIN_W + FRAC_BITS : 32) + 2;
  localparam int MAG_W  = RATE_W - 1;
  localparam int NUM_W  = DTC_W + MAG_W;
  localparam int RND_W  = NUM_W + 1;

  // divide by 256e6 = 2^14 * 15625, rounded half away from zero
  localparam longint DEN_HALF  = 128000000;
  localparam int     DEN_SHIFT = 14;
  localparam longint DEN_ODD   = 15625;

  // quotient only needs to be exact up to twice the limit, larger values saturate
  localparam int XW       = $clog2(2 * LIMIT * DEN_ODD);
  localparam int RECIP_SH = XW + DEN_SHIFT;
  localparam int Q_W      = XW - (DEN_SHIFT - 1);
  localparam logic [XW:0] RECIP =
    (XW + 1)'(((longint'(1) << RECIP_SH) + DEN_ODD - 1) / DEN_ODD);

  // integral plus increment
  localparam int SUM_W = ((INT_W > Q_W + 1) ? INT_W : Q_W + 1) + 1;

  localparam logic signed [SUM_W-1:0] LIM_S   = SUM_W'(LIMIT);
  localparam logic signed [SUM_W-1:0] LIM_SN  = SUM_W'(-LIMIT);
  localparam logic signed [INT_W-1:0] LIM_I   = INT_W'(LIMIT);
  localparam logic signed [INT_W-1:0] LIM_IN  = INT_W'(-LIMIT);
  localparam logic signed [CMP_W-1:0] STRONG_P = CMP_W'(STRONG);
  localparam logic signed [CMP_W-1:0] STRONG_N = CMP_W'(-STRONG);
  localparam logic signed [CMP_W-1:0] LIGHT_P  = CMP_W'(LIGHT);
  localparam logic signed [CMP_W-1:0] LIGHT_N  = CMP_W'(-LIGHT);

  // drive modes
  localparam logic [MODE_W-1:0] M_NEUTRAL  = 2'd0;
  localparam logic [MODE_W-1:0] M_BRAKE    = 2'd1;
  localparam logic [MODE_W-1:0] M_B2T      = 2'd2;
  localparam logic [MODE_W-1:0] M_THROTTLE = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOW_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUCK_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIND_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIND_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_EN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_EN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_EN    = 3'd7;

  // register reset values
  localparam logic [GAIN_W-1:0] BLOW_GAIN_RST = 16'd64;
  localparam logic [GAIN_W-1:0] SUCK_GAIN_RST = 16'd256;
  localparam logic [DB_W-1:0]   DEAD_BAND_RST = 15'd2560;

  typedef struct packed {
    logic [GAIN_W-1:0] blow_gain;
    logic [GAIN_W-1:0] suck_gain;
    logic [DB_W-1:0]   dead_band;
    logic [GAIN_W-1:0] mind_throttle_gain;
    logic              mind_mode;
    logic              integration_enable;
    logic              throttle_enable;
    logic              brake_enable;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic rate;
    logic prod;
    logic rnd;
    logic div;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  // clamp a sum to +-100 percent
  function automatic logic signed [INT_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
    logic signed [INT_W-1:0] r;
    if (v > LIM_S) begin
      r = LIM_I;
    end else if (v < LIM_SN) begin
      r = LIM_IN;
    end else begin
      r = v[INT_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/sipt_in_if.sv
// sample channel: valid/ready with pressure, elapsed time and throttle-on
`timescale 1ns / 1ps

interface sipt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sipt_pkg::PRESS_W-1:0]  pressure;
  logic        [sipt_pkg::DT_W-1:0]     elapsed_us;
  logic                                 throttle_on;

  modport source (output valid, pressure, elapsed_us, throttle_on, input ready);
  modport sink   (input valid, pressure, elapsed_us, throttle_on, output ready);
endinterface

>>> rtl/sipt_out_if.sv
// result channel: valid/ready with command and mode
`timescale 1ns / 1ps

interface sipt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sipt_pkg::CMD_W-1:0]   command;
  logic        [sipt_pkg::MODE_W-1:0]  mode_now;

  modport source (output valid, command, mode_now, input ready);
  modport sink   (input valid, command, mode_now, output ready);
endinterface

>>> rtl/sipt_cfg.sv
// configuration register file with integral clear strobe
`timescale 1ns / 1ps

module sipt_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [sipt_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [sipt_pkg::CFG_DATA_W-1:0]  wr_data,
  output sipt_pkg::cfg_t                   cfg,
  output logic                             clear
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blow_gain          <= sipt_pkg::BLOW_GAIN_RST;
      cfg.suck_gain          <= sipt_pkg::SUCK_GAIN_RST;
      cfg.dead_band          <= sipt_pkg::DEAD_BAND_RST;
      cfg.mind_throttle_gain <= '0;
      cfg.mind_mode          <= 1'b0;
      cfg.integration_enable <= 1'b1;
      cfg.throttle_enable    <= 1'b0;
      cfg.brake_enable       <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        sipt_pkg::REG_BLOW_GAIN:   cfg.blow_gain          <= wr_data;
        sipt_pkg::REG_SUCK_GAIN:   cfg.suck_gain          <= wr_data;
        sipt_pkg::REG_DEAD_BAND:   cfg.dead_band          <= wr_data[sipt_pkg::DB_W-1:0];
        sipt_pkg::REG_MIND_GAIN:   cfg.mind_throttle_gain <= wr_data;
        sipt_pkg::REG_MIND_MODE:   cfg.mind_mode          <= wr_data[0];
        sipt_pkg::REG_INTEG_EN:    cfg.integration_enable <= wr_data[0];
        sipt_pkg::REG_THROTTLE_EN: cfg.throttle_enable    <= wr_data[0];
        sipt_pkg::REG_BRAKE_EN:    cfg.brake_enable       <= wr_data[0];
        default: ;
      endcase
    end
  end

  // any write to a known register restarts the integral
  assign clear = wr_en &&
                 (wr_index inside {[sipt_pkg::REG_BLOW_GAIN:sipt_pkg::REG_BRAKE_EN]});

endmodule

>>> rtl/sipt_ctrl.sv
// sequencer that steps one sample through the datapath
`timescale 1ns / 1ps

module sipt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output sipt_pkg::dp_cmd_t   cmd,
  input  sipt_pkg::dp_sts_t   sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RATE  = 3'd1;
  localparam logic [2:0] S_PROD  = 3'd2;
  localparam logic [2:0] S_RND   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_RATE;
      S_RATE:  state_next = S_PROD;
      S_PROD:  state_next = S_RND;
      S_RND:   state_next = S_DIV;
      S_DIV:   state_next = S_UPD;
      S_UPD:   if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.rate   = (state == S_RATE);
  assign cmd.prod   = (state == S_PROD);
  assign cmd.rnd    = (state == S_RND);
  assign cmd.div    = (state == S_DIV);
  assign cmd.commit = (state == S_UPD) && sts.out_free;

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("datapath commands overlap");

  a_step_order: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.rate ##1 cmd.prod ##1 cmd.rnd ##1 cmd.div)
    else $error("datapath steps out of order");

endmodule

>>> rtl/sipt_dp.sv
// datapath: rate multiply, time product, rounding, reciprocal divide, mode update
`timescale 1ns / 1ps

module sipt_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sipt_pkg::cfg_t                       cfg,
  input  logic                                 clear,
  input  sipt_pkg::dp_cmd_t                    cmd,
  output sipt_pkg::dp_sts_t                    sts,
  input  logic signed [sipt_pkg::PRESS_W-1:0]  pressure,
  input  logic        [sipt_pkg::DT_W-1:0]     elapsed_us,
  input  logic                                 throttle_on,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [sipt_pkg::CMD_W-1:0]    command,
  output logic        [sipt_pkg::MODE_W-1:0]   mode_now
);

  localparam int PW = sipt_pkg::PRESS_W;
  localparam int CW = sipt_pkg::CMP_W;
  localparam int RW = sipt_pkg::RATE_W;
  localparam int SW = sipt_pkg::SUM_W;
  localparam int IW = sipt_pkg::INT_W;
  localparam int XW = sipt_pkg::XW;
  localparam int GW = sipt_pkg::GAIN_W;

  // sample and pipeline registers
  logic signed [PW-1:0]                p_r;
  logic [sipt_pkg::DTC_W-1:0]          dt_r;
  logic                                ton_r;
  logic [RW-1:0]                       rate_r;
  logic                                neg_r;
  logic [sipt_pkg::NUM_W-1:0]          num_r;
  logic [XW-1:0]                       x_r;
  logic                                ovf_r;
  logic [sipt_pkg::Q_W-1:0]            q_r;

  // block state
  logic signed [IW-1:0]                integral;
  logic [sipt_pkg::MODE_W-1:0]         mode;

  // input clamp
  logic [sipt_pkg::DTC_W-1:0] dt_clamp;
  always_comb begin
    if (elapsed_us < sipt_pkg::DT_W'(sipt_pkg::DT_MIN)) begin
      dt_clamp = sipt_pkg::DTC_W'(sipt_pkg::DT_MIN);
    end else if (elapsed_us > sipt_pkg::DT_W'(sipt_pkg::DT_MAX)) begin
      dt_clamp = sipt_pkg::DTC_W'(sipt_pkg::DT_MAX);
    end else begin
      dt_clamp = elapsed_us[sipt_pkg::DTC_W-1:0];
    end
  end

  // sample comparisons
  logic signed [CW-1:0] p_w;
  logic signed [CW-1:0] ap_w;
  logic signed [CW-1:0] db_w;
  logic p_pos, p_neg, p_gt_db, p_lt_ndb, active;

  assign p_w      = $signed({{(CW-PW){p_r[PW-1]}}, p_r});
  assign ap_w     = p_r[PW-1] ? -p_w : p_w;
  assign db_w     = $signed({{(CW-sipt_pkg::DB_W){1'b0}}, cfg.dead_band});
  assign p_pos    = p_w > 0;
  assign p_neg    = p_r[PW-1];
  assign p_gt_db  = p_w > db_w;
  assign p_lt_ndb = p_w < -db_w;
  assign active   = (ap_w > db_w) || (cfg.mind_mode && ton_r);

  // rate selection
  logic [GW-1:0] sg_floor;
  logic [GW-1:0] gain_sel;
  logic          use_base;

  assign sg_floor = (cfg.suck_gain < GW'(sipt_pkg::SUCK_FLOOR)) ?
                    GW'(sipt_pkg::SUCK_FLOOR) : cfg.suck_gain;

  always_comb begin
    gain_sel = '0;
    use_base = 1'b0;
    if (!cfg.mind_mode) begin
      case (mode)
        sipt_pkg::M_BRAKE:    gain_sel = cfg.suck_gain;
        sipt_pkg::M_THROTTLE: gain_sel = cfg.blow_gain;
        default: ;
      endcase
    end else begin
      case (mode)
        sipt_pkg::M_BRAKE: begin
          if (!p_neg && ton_r) begin
            gain_sel = cfg.blow_gain;
            use_base = 1'b1;
          end else begin
            gain_sel = sg_floor;
          end
        end
        sipt_pkg::M_THROTTLE: begin
          if (p_lt_ndb) begin
            gain_sel = sg_floor;
          end else if (ton_r) begin
            use_base = 1'b1;
            if (p_gt_db) gain_sel = cfg.blow_gain;
          end
        end
        default: ;
      endcase
    end
  end

  logic signed [GW+PW:0] gp;
  logic [RW-1:0]         base_w;
  logic [RW-1:0]         rate_next;

  assign gp        = $signed({1'b0, gain_sel}) * p_r;
  assign base_w    = {{(RW-GW-sipt_pkg::FRAC_BITS){1'b0}}, cfg.mind_throttle_gain,
                      {sipt_pkg::FRAC_BITS{1'b0}}};
  assign rate_next = {{(RW-GW-PW-1){gp[GW+PW]}}, gp} + (use_base ? base_w : '0);

  // magnitude times elapsed time
  logic [RW-1:0]                 rate_neg;
  logic [sipt_pkg::MAG_W-1:0]    mag;
  logic [sipt_pkg::NUM_W-1:0]    num_next;

  assign rate_neg = -rate_r;
  assign mag      = rate_r[RW-1] ? rate_neg[sipt_pkg::MAG_W-1:0] : rate_r[sipt_pkg::MAG_W-1:0];
  assign num_next = {{sipt_pkg::MAG_W{1'b0}}, dt_r} * {{sipt_pkg::DTC_W{1'b0}}, mag};

  // add half the divisor, drop the power-of-two part
  logic [sipt_pkg::RND_W-1:0] rnd;
  assign rnd = {1'b0, num_r} + sipt_pkg::RND_W'(sipt_pkg::DEN_HALF);

  // reciprocal multiply for the odd part of the divisor
  logic [2*XW:0] qprod;
  assign qprod = {{(XW+1){1'b0}}, x_r} * {{XW{1'b0}}, sipt_pkg::RECIP};

  // update
  logic signed [SW-1:0] qe, incr, iv_e, iv_b, iv_t, sum_b, sum_t, p_sum;
  logic signed [IW-1:0] int_nx;
  logic [sipt_pkg::MODE_W-1:0] mode_nx;
  logic disabled;

  assign qe       = $signed({{(SW-sipt_pkg::Q_W){1'b0}}, q_r});
  assign incr     = neg_r ? -qe : qe;
  assign iv_e     = $signed({{(SW-IW){integral[IW-1]}}, integral});
  assign iv_b     = (iv_e > 0) ? '0 : iv_e;
  assign iv_t     = (iv_e < 0) ? '0 : iv_e;
  assign sum_b    = iv_b + incr;
  assign sum_t    = iv_t + incr;
  assign p_sum    = $signed({{(SW-PW){p_r[PW-1]}}, p_r});
  assign disabled = !cfg.integration_enable || !(cfg.throttle_enable || cfg.brake_enable);

  always_comb begin
    int_nx  = integral;
    mode_nx = mode;
    if (disabled) begin
      int_nx  = '0;
      mode_nx = sipt_pkg::M_NEUTRAL;
    end else if (active) begin
      case (mode)
        sipt_pkg::M_NEUTRAL: begin
          int_nx = '0;
          if (cfg.mind_mode ? ton_r : (p_pos && cfg.throttle_enable)) begin
            mode_nx = sipt_pkg::M_THROTTLE;
          end else if (p_neg && cfg.brake_enable) begin
            mode_nx = sipt_pkg::M_BRAKE;
          end
        end
        sipt_pkg::M_BRAKE: begin
          if (!cfg.brake_enable) begin
            mode_nx = sipt_pkg::M_B2T;
          end else if (p_w > sipt_pkg::STRONG_P) begin
            int_nx = '0;
            if (cfg.throttle_enable || cfg.mind_mode) mode_nx = sipt_pkg::M_B2T;
          end else if (cfg.mind_mode || (cfg.suck_gain != '0)) begin
            if (sum_b >= 0) begin
              int_nx = '0;
              if (cfg.throttle_enable) mode_nx = sipt_pkg::M_B2T;
            end else begin
              int_nx = sipt_pkg::sat_sum(sum_b);
            end
          end else if (p_neg) begin
            // zero gain: command follows the sip
            int_nx = sipt_pkg::sat_sum(p_sum);
          end else if ((p_w > sipt_pkg::LIGHT_P) && cfg.throttle_enable) begin
            int_nx  = '0;
            mode_nx = sipt_pkg::M_B2T;
          end else begin
            int_nx = '0;
          end
        end
        sipt_pkg::M_B2T: begin
          int_nx = '0;
          if (cfg.throttle_enable) begin
            if (p_w < sipt_pkg::STRONG_N) begin
              mode_nx = sipt_pkg::M_BRAKE;
            end else if (p_w < sipt_pkg::STRONG_P) begin
              mode_nx = sipt_pkg::M_THROTTLE;
            end
          end else begin
            mode_nx = cfg.brake_enable ? sipt_pkg::M_BRAKE : sipt_pkg::M_NEUTRAL;
          end
        end
        default: begin
          if (!cfg.throttle_enable) begin
            mode_nx = sipt_pkg::M_NEUTRAL;
          end else if (p_w < sipt_pkg::STRONG_N) begin
            int_nx = '0;
            if (cfg.brake_enable) mode_nx = sipt_pkg::M_BRAKE;
          end else if (cfg.mind_mode || (cfg.blow_gain != '0)) begin
            if (sum_t < 0) begin
              int_nx = '0;
              if (cfg.brake_enable) mode_nx = sipt_pkg::M_NEUTRAL;
            end else begin
              int_nx = sipt_pkg::sat_sum(sum_t);
            end
          end else if (p_pos) begin
            // zero gain: command follows the puff
            int_nx = sipt_pkg::sat_sum(p_sum);
          end else if (p_w < sipt_pkg::LIGHT_N) begin
            int_nx = '0;
            if (cfg.brake_enable) mode_nx = sipt_pkg::M_NEUTRAL;
          end
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r   <= pressure;
      dt_r  <= dt_clamp;
      ton_r <= throttle_on;
    end
    if (cmd.rate) begin
      rate_r <= rate_next;
    end
    if (cmd.prod) begin
      num_r <= num_next;
      neg_r <= rate_r[RW-1];
    end
    if (cmd.rnd) begin
      x_r   <= rnd[sipt_pkg::DEN_SHIFT+XW-1:sipt_pkg::DEN_SHIFT];
      ovf_r <= |rnd[sipt_pkg::RND_W-1:sipt_pkg::DEN_SHIFT+XW];
    end
    if (cmd.div) begin
      q_r <= ovf_r ? '1 : qprod[2*XW:sipt_pkg::RECIP_SH];
    end
    if (cmd.commit) begin
      command  <= int_nx[sipt_pkg::CMD_W-1:0];
      mode_now <= mode_nx;
    end
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      integral  <= '0;
      mode      <= sipt_pkg::M_NEUTRAL;
      out_valid <= 1'b0;
    end else begin
      if (clear) begin
        integral <= '0;
      end else if (cmd.commit) begin
        integral <= int_nx;
      end
      if (cmd.commit) begin
        mode      <= mode_nx;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid || out_ready;

  a_integral_range: assert property (@(posedge clk) disable iff (rst)
    (integral <= sipt_pkg::LIM_I) && (integral >= sipt_pkg::LIM_IN))
    else $error("integral beyond limit");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    clear |=> (integral == '0))
    else $error("register write did not clear integral");

  a_disabled_neutral: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && disabled && !clear) |=>
      (mode == sipt_pkg::M_NEUTRAL) && (integral == '0) && (mode_now == mode))
    else $error("disabled block not neutral");

endmodule

>>> rtl/sip_puff_brake_throttle_integrator_top.sv
// top level of the sip/puff brake-throttle integrator
`timescale 1ns / 1ps

// Sip/puff brake-throttle integrator. Each sample transfer carries a signed
// pressure in percent Q8 (sip negative, puff positive), the microseconds since
// the previous sample and a throttle-on request; each sample produces exactly
// one result transfer with the saturated brake/throttle command and the
// current mode (neutral, brake, brake-to-throttle, throttle). One sample is
// worked at a time and goes from the sample transfer to the result register
// through the gain-times-pressure multiply, the time product, the
// rounding add, the reciprocal multiply that divides by 256e6, and the mode
// update, each a registered step of the sequencer. The next sample is taken
// in the cycle after the update while the result side keeps up; a held
// result stalls the update step only, not the previous result. Registers are
// to be written through the plain write port only while the block is idle;
// the block itself does not enforce this. Every write clears the integral.
module sip_puff_brake_throttle_integrator_top (
  input  logic                             clk,
  input  logic                             rst,
  sipt_in_if.sink                          sample,
  sipt_out_if.source                       result,
  input  logic                             wr_en,
  input  logic [sipt_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [sipt_pkg::CFG_DATA_W-1:0]  wr_data
);

  sipt_pkg::cfg_t     cfg;
  sipt_pkg::dp_cmd_t  cmd;
  sipt_pkg::dp_sts_t  sts;
  logic               clear;

  // register file
  sipt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg),
    .clear    (clear)
  );

  // step sequencer, owns the sample-side ready
  sipt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // arithmetic, mode state and the result register
  sipt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .clear       (clear),
    .cmd         (cmd),
    .sts         (sts),
    .pressure    (sample.pressure),
    .elapsed_us  (sample.elapsed_us),
    .throttle_on (sample.throttle_on),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .command     (result.command),
    .mode_now    (result.mode_now)
  );

endmodule
